>>> rtl/cq_pkg.sv
// shared types and constants for the circular queue with insert
package cq_pkg;

    localparam int ACTION_W   = 2;
    localparam int POSITION_W = 4;
    localparam int ELEM_PORT_W = 32;
    localparam int COUNT_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT,
        ST_PLACE,
        ST_DONE
    } cq_state_t;

    typedef struct packed {
        logic latch;
        logic push;
        logic pop;
        logic shift_begin;
        logic shift_step;
        logic place;
        logic set_flags;
        logic ok_val;
        logic take_val;
        logic load_result;
    } cq_cmd_t;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic                pos_ge_count;
        logic                at_target;
        logic [ACTION_W-1:0] action;
    } cq_status_t;

endpackage

>>> rtl/cq_req_if.sv
// request channel: one queue operation per transaction
interface cq_req_if;
    import cq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [POSITION_W-1:0] position;
    logic [ELEM_PORT_W-1:0] element;

    modport source (output valid, output action, output position, output element, input ready);
    modport sink   (input valid, input action, input position, input element, output ready);
endinterface

>>> rtl/cq_rsp_if.sv
// response channel: one result per transaction
interface cq_rsp_if;
    import cq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [ELEM_PORT_W-1:0] element_out;
    logic [COUNT_W-1:0]     count;

    modport source (output valid, output ok, output element_out, output count, input ready);
    modport sink   (input valid, input ok, input element_out, input count, output ready);
endinterface

>>> rtl/cq_ram.sv
// generic single write port ram with registered read
module cq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cq_datapath.sv
// queue datapath: indices, fill count, slot store and result register
module cq_datapath #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cq_pkg::cq_cmd_t                cmd,
    output cq_pkg::cq_status_t             status,
    input  logic [cq_pkg::ACTION_W-1:0]    req_action,
    input  logic [cq_pkg::POSITION_W-1:0]  req_position,
    input  logic [cq_pkg::ELEM_PORT_W-1:0] req_element,
    output logic                           rsp_ok,
    output logic [cq_pkg::ELEM_PORT_W-1:0] rsp_element_out,
    output logic [cq_pkg::COUNT_W-1:0]     rsp_count
);
    import cq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = ((AW > POSITION_W) ? AW : POSITION_W) + 1;
    localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        return (i == LAST_SLOT) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
        return (i == '0) ? LAST_SLOT : i - AW'(1);
    endfunction

    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            cur_reg;
    logic [AW-1:0]            target_reg;
    logic [ACTION_W-1:0]      action_reg;
    logic [POSITION_W-1:0]    pos_reg;
    logic [ELEMENT_WIDTH-1:0] elem_reg;
    logic                     ok_reg;
    logic                     take_reg;
    logic                     rsp_ok_reg;
    logic [ELEM_PORT_W-1:0]   rsp_elem_reg;
    logic [COUNT_W-1:0]       rsp_count_reg;

    logic [AW-1:0]            cur_prev;
    logic [AW-1:0]            cur_prev2;
    logic [AW-1:0]            tail_succ;
    logic [SW-1:0]            target_sum;
    logic [AW-1:0]            target_calc;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [ELEMENT_WIDTH-1:0] ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [ELEMENT_WIDTH-1:0] ram_rdata;

    assign cur_prev   = ring_prev(cur_reg);
    assign cur_prev2  = ring_prev(cur_prev);
    assign tail_succ  = ring_next(tail_reg);
    assign target_sum = SW'(head_reg) + SW'(pos_reg);
    assign target_calc = (target_sum >= SW'(QUEUE_DEPTH)) ?
                         AW'(target_sum - SW'(QUEUE_DEPTH)) : AW'(target_sum);

    // index and count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push || cmd.place)
        begin
            tail_next  = tail_succ;
            count_next = count_reg + CW'(1);
        end
        if (cmd.pop)
        begin
            head_next  = ring_next(head_reg);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= LAST_SLOT;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= req_action;
            pos_reg    <= req_position;
            elem_reg   <= ELEMENT_WIDTH'(req_element);
        end
        if (cmd.shift_begin)
        begin
            cur_reg    <= tail_succ;
            target_reg <= target_calc;
        end
        else if (cmd.shift_step)
        begin
            cur_reg <= cur_prev;
        end
        if (cmd.set_flags)
        begin
            ok_reg   <= cmd.ok_val;
            take_reg <= cmd.take_val;
        end
        if (cmd.load_result)
        begin
            rsp_ok_reg    <= ok_reg;
            rsp_elem_reg  <= take_reg ? ELEM_PORT_W'(ram_rdata) : '0;
            rsp_count_reg <= COUNT_W'(count_reg);
        end
    end

    // slot store access: shifting reads two slots ahead of the write, since the read is registered
    always_comb
    begin
        ram_we    = cmd.push || cmd.shift_step || cmd.place;
        ram_waddr = cmd.push ? tail_succ : (cmd.shift_step ? cur_reg : target_reg);
        ram_wdata = cmd.shift_step ? ram_rdata : elem_reg;
        ram_re    = cmd.pop || cmd.shift_begin || cmd.shift_step;
        ram_raddr = cmd.pop ? head_reg : (cmd.shift_begin ? tail_reg : cur_prev2);
    end

    cq_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.full         = (count_reg == CW'(QUEUE_DEPTH));
    assign status.empty        = (count_reg == '0);
    assign status.pos_ge_count = (PW'(pos_reg) >= PW'(count_reg));
    assign status.at_target    = (cur_prev == target_reg);
    assign status.action       = action_reg;

    assign rsp_ok          = rsp_ok_reg;
    assign rsp_element_out = rsp_elem_reg;
    assign rsp_count       = rsp_count_reg;

endmodule

>>> rtl/cq_ctrl.sv
// queue controller: operation sequencing and response handshake
module cq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  cq_pkg::cq_status_t status,
    output cq_pkg::cq_cmd_t    cmd
);
    import cq_pkg::*;

    cq_state_t state_reg, state_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.action == ACT_INSERT && !status.full && !status.pos_ge_count)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (status.at_target)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
            end
            ST_DECODE:
            begin
                cmd.set_flags = 1'b1;
                case (status.action)
                    ACT_ENQUEUE:
                    begin
                        if (!status.full)
                        begin
                            cmd.push   = 1'b1;
                            cmd.ok_val = 1'b1;
                        end
                    end
                    ACT_DEQUEUE:
                    begin
                        if (!status.empty)
                        begin
                            cmd.pop      = 1'b1;
                            cmd.ok_val   = 1'b1;
                            cmd.take_val = 1'b1;
                        end
                    end
                    ACT_INSERT:
                    begin
                        if (!status.full)
                        begin
                            cmd.ok_val = 1'b1;
                            if (status.pos_ge_count)
                            begin
                                cmd.push = 1'b1;
                            end
                            else
                            begin
                                cmd.shift_begin = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        cmd.ok_val = 1'b0;
                    end
                endcase
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
            end
            ST_PLACE:
            begin
                cmd.place = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_result = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign out_valid_next = cmd.load_result ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

>>> rtl/circular_queue_with_insert.sv
// circular queue with positional insert, top level
// enqueue, dequeue and rejected transactions pass through decode and done to a held result
// an insert that moves slots also passes through shift and place, one slot a cycle through the ram ports
// throughput: one transaction at a time, a new request is accepted only in the idle state
// reset: head 0, tail at the last slot, count 0, no response pending; slots not cleared
module circular_queue_with_insert #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    cq_req_if.sink    req,
    cq_rsp_if.source  rsp
);
    import cq_pkg::*;

    cq_cmd_t    cmd;
    cq_status_t status;

    cq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req_action      (req.action),
        .req_position    (req.position),
        .req_element     (req.element),
        .rsp_ok          (rsp.ok),
        .rsp_element_out (rsp.element_out),
        .rsp_count       (rsp.count)
    );

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push, cmd.pop, cmd.shift_begin, cmd.shift_step, cmd.place}))
        else $error("more than one slot operation in a cycle");

    a_no_grow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.shift_begin || cmd.place) |-> !status.full)
        else $error("queue grown while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !status.empty)
        else $error("pop from empty queue");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> rsp.valid)
        else $error("loaded result not presented");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("transaction accepted while another is in progress");

endmodule

>>> verif/circular_queue_with_insert_checker.sv
// checker: predicts queue results from observed requests and compares them with responses
module circular_queue_with_insert_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    cq_req_if    req,
    cq_rsp_if    rsp,
    output int   mismatches,
    output int   pending
);
    import cq_pkg::*;

    typedef struct packed {
        logic                   ok;
        logic [ELEM_PORT_W-1:0] element_out;
        logic [COUNT_W-1:0]     count;
    } queue_result_t;

    logic [ELEM_PORT_W-1:0] contents[$];
    queue_result_t          results_due[$];
    int                     fail_total;

    function automatic queue_result_t apply_op(
        input logic [ACTION_W-1:0]    action,
        input logic [POSITION_W-1:0]  position,
        input logic [ELEM_PORT_W-1:0] element
    );
        queue_result_t outcome;
        outcome = '0;
        case (action)
            ACT_ENQUEUE:
            begin
                if (contents.size() < QUEUE_DEPTH)
                begin
                    contents.push_back(element);
                    outcome.ok = 1'b1;
                end
            end
            ACT_DEQUEUE:
            begin
                if (contents.size() > 0)
                begin
                    outcome.element_out = contents.pop_front();
                    outcome.ok = 1'b1;
                end
            end
            ACT_INSERT:
            begin
                if (contents.size() < QUEUE_DEPTH)
                begin
                    // a position at or past the fill level appends at the rear
                    if (int'(position) >= contents.size())
                        contents.push_back(element);
                    else
                        contents.insert(int'(position), element);
                    outcome.ok = 1'b1;
                end
            end
            default: ;
        endcase
        outcome.count = COUNT_W'(contents.size());
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        if (!rst_n)
        begin
            contents.delete();
            results_due.delete();
            fail_total = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                results_due.push_back(apply_op(req.action, req.position, req.element));
            if (rsp.valid && rsp.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected transaction: ok %0b element_out %h count %0d",
                           rsp.ok, rsp.element_out, rsp.count);
                    fail_total++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (rsp.ok !== want.ok)
                    begin
                        $error("ok: expected %0b, actual %0b", want.ok, rsp.ok);
                        fail_total++;
                    end
                    if (rsp.element_out !== want.element_out)
                    begin
                        $error("element_out: expected %h, actual %h",
                               want.element_out, rsp.element_out);
                        fail_total++;
                    end
                    if (rsp.count !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, rsp.count);
                        fail_total++;
                    end
                end
            end
            mismatches <= fail_total;
            pending    <= results_due.size();
        end
    end

endmodule

>>> verif/circular_queue_with_insert_tb.sv
// testbench top: drives queue operations, paces both channels and gives the verdict
module circular_queue_with_insert_tb;
    import cq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_OPS   = 800;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [ACTION_W-1:0]    ACT_UNUSED = 2'd3;
    localparam logic [ELEM_PORT_W-1:0] ELEM_ONES  = '1;
    localparam logic [POSITION_W-1:0]  POS_LAST   = '1;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   cycles;
    bit   long_hold;
    bit   steady;

    cq_req_if req();
    cq_rsp_if rsp();

    circular_queue_with_insert #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .ELEMENT_WIDTH (ELEM_PORT_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    circular_queue_with_insert_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) queue_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(input int push_share);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return ACT_UNUSED;
        roll = $urandom_range(0, 99);
        if (roll >= push_share)
            return ACT_DEQUEUE;
        return ($urandom_range(0, 1) == 0) ? ACT_ENQUEUE : ACT_INSERT;
    endfunction

    function automatic logic [ELEM_PORT_W-1:0] pick_element();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        else if (roll < 16)
            return ELEM_ONES;
        else
            return $urandom;
    endfunction

    task automatic send_op(
        input logic [ACTION_W-1:0]    action,
        input logic [POSITION_W-1:0]  position,
        input logic [ELEM_PORT_W-1:0] element
    );
        req.valid    <= 1'b1;
        req.action   <= action;
        req.position <= position;
        req.element  <= element;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic idle_sender();
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // response side: random back-pressure, with one long hold-off on request
    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                gap = steady ? 0 : pick_gap();
                if (gap > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("circular_queue_with_insert_tb: FAIL");
        $finish;
    end

    initial
    begin
        int push_share;
        int n;
        req.valid    = 1'b0;
        req.action   = ACT_ENQUEUE;
        req.position = '0;
        req.element  = '0;
        long_hold    = 1'b0;
        steady       = 1'b0;
        rst_n        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corner cases
        send_op(ACT_DEQUEUE, '0, ELEM_ONES);
        idle_sender();
        send_op(ACT_UNUSED, POS_LAST, ELEM_ONES);
        idle_sender();
        send_op(ACT_INSERT, POS_LAST, 32'h1000_0001);
        idle_sender();
        send_op(ACT_ENQUEUE, '0, '0);
        idle_sender();
        send_op(ACT_ENQUEUE, '0, ELEM_ONES);
        idle_sender();
        // insert at the front and in the middle
        send_op(ACT_INSERT, '0, 32'h1000_0002);
        idle_sender();
        send_op(ACT_INSERT, 4'd2, 32'h1000_0003);
        idle_sender();
        for (n = 5; n < QUEUE_DEPTH; n++)
        begin
            send_op(ACT_ENQUEUE, '0, 32'h2000_0000 + n);
            idle_sender();
        end
        // full queue corner cases
        send_op(ACT_ENQUEUE, '0, 32'h3000_0001);
        idle_sender();
        send_op(ACT_INSERT, '0, 32'h3000_0002);
        idle_sender();
        send_op(ACT_UNUSED, '0, '0);
        idle_sender();
        for (n = 0; n < 4; n++)
        begin
            send_op(ACT_DEQUEUE, '0, '0);
            idle_sender();
        end
        wait_drained();

        for (n = 0; n < RANDOM_OPS; n++)
        begin
            case ((n / 100) % 4)
                0:       push_share = 75;
                1:       push_share = 30;
                2:       push_share = 60;
                default: push_share = 20;
            endcase
            steady = ((n / 100) % 3) == 2;
            if (n == 200)
                long_hold = 1'b1;
            if (n == 450)
                wait_drained();
            send_op(pick_action(push_share), POSITION_W'($urandom_range(0, 15)),
                    pick_element());
            // keep offering back to back while the receiver holds off
            if (!long_hold)
                idle_sender();
        end
        steady = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("circular_queue_with_insert_tb: PASS");
        else
            $display("circular_queue_with_insert_tb: FAIL");
        $finish;
    end

endmodule
